// ----- sv/mah_pkg.sv -----
// ----------------------------------------------------------------------------
// mah_pkg
// Shared widths, depths and register indexes for the moving average block.
// ----------------------------------------------------------------------------
package mah_pkg;

    localparam int AVG_LEN_LOG2 = 3;
    localparam int RING_DEPTH   = 1 << AVG_LEN_LOG2;
    localparam int SAMPLE_W     = 10;
    localparam int SUM_W        = SAMPLE_W + AVG_LEN_LOG2;
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = 10;

    typedef logic [SAMPLE_W-1:0]     sample_t;
    typedef logic [SUM_W-1:0]        sum_t;
    typedef logic [AVG_LEN_LOG2-1:0] ptr_t;
    typedef logic [CFG_IDX_W-1:0]    cfg_idx_t;

    localparam cfg_idx_t REG_THRESHOLD_LOW  = 1'd0;
    localparam cfg_idx_t REG_THRESHOLD_HIGH = 1'd1;

    localparam sample_t THRESHOLD_LOW_RST  = 10'd0;
    localparam sample_t THRESHOLD_HIGH_RST = 10'd1023;

endpackage

// ----- sv/mah_if.sv -----
// ----------------------------------------------------------------------------
// mah_sample_if / mah_result_if
// Valid/ready channels carrying sample items in and average items out.
// ----------------------------------------------------------------------------
interface mah_sample_if
    import mah_pkg::*;
;
    logic    valid;
    logic    ready;
    sample_t sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface mah_result_if
    import mah_pkg::*;
;
    logic    valid;
    logic    ready;
    sample_t average;
    logic    force_high;

    modport source (output valid, output average, output force_high, input ready);
    modport sink   (input valid, input average, input force_high, output ready);
endinterface

// ----- sv/mah_ring_avg.sv -----
// ----------------------------------------------------------------------------
// mah_ring_avg
// Sample ring, write pointer and running sum; gives the updated average.
// ----------------------------------------------------------------------------
module mah_ring_avg
    import mah_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    step_en,
    input  sample_t sample,
    output sample_t average
);

    sample_t ring_reg [RING_DEPTH];
    ptr_t    ptr_reg;
    sum_t    sum_reg;
    sum_t    sum_next;

    // add the new sample, drop the one it overwrites
    assign sum_next = sum_reg + sum_t'(sample) - sum_t'(ring_reg[ptr_reg]);
    assign average  = sum_next[SUM_W-1:AVG_LEN_LOG2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < RING_DEPTH; i++)
            begin
                ring_reg[i] <= '0;
            end
            ptr_reg <= '0;
            sum_reg <= '0;
        end
        else if (step_en)
        begin
            ring_reg[ptr_reg] <= sample;
            ptr_reg           <= ptr_reg + ptr_t'(1);
            sum_reg           <= sum_next;
        end
    end

endmodule

// ----- sv/mah_hyst.sv -----
// ----------------------------------------------------------------------------
// mah_hyst
// Force flag with hysteresis between a low and a high threshold.
// ----------------------------------------------------------------------------
module mah_hyst
    import mah_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    step_en,
    input  sample_t average,
    input  sample_t thr_low,
    input  sample_t thr_high,
    output logic    force_next
);

    logic force_reg;

    always_comb
    begin
        force_next = force_reg;
        if (force_reg && (average < thr_low))
        begin
            force_next = 1'b0;
        end
        else if (!force_reg && (average > thr_high))
        begin
            force_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            force_reg <= 1'b0;
        end
        else if (step_en)
        begin
            force_reg <= force_next;
        end
    end

endmodule

// ----- sv/moving_average_hysteresis_flag.sv -----
// ----------------------------------------------------------------------------
// moving_average_hysteresis_flag
// Moving average over the last 8 samples with a hysteresis force flag.
// ----------------------------------------------------------------------------
// Usage:
//   sample_ch carries one 10-bit converter sample per item. result_ch returns
//   one item per sample: the average of the ring after the sample is stored
//   and the force flag after its update.
//   Thresholds are written through cfg_we/cfg_index/cfg_data while the block
//   is idle; index 0 is the low threshold, index 1 the high threshold.
// Timing:
//   An accepted sample lands in the input register; once the result register
//   can advance, the running sum, average and flag are computed in one pass
//   and captured in the result register, which then raises result valid.
//   Throughput is one item per cycle while result_ch is not stalled.
// Reset:
//   rst_n clears the ring, pointer, sum and flag; thresholds return to 0 and
//   1023. The block is ready right after reset.
// Stall:
//   When result_ch is stalled the result holds and the input register fills;
//   sample_ch then drops ready until the result is taken.
// ----------------------------------------------------------------------------
module moving_average_hysteresis_flag
    import mah_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  cfg_idx_t              cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    mah_sample_if.sink            sample_ch,
    mah_result_if.source          result_ch
);

    sample_t thr_low_reg;
    sample_t thr_high_reg;
    sample_t in_sample_reg;
    logic    in_valid_reg;
    sample_t out_average_reg;
    logic    out_force_reg;
    logic    out_valid_reg;
    logic    advance;
    logic    step_en;
    sample_t average;
    logic    force_next;

    assign advance         = !out_valid_reg || result_ch.ready;
    assign step_en         = in_valid_reg && advance;
    assign sample_ch.ready = !in_valid_reg || advance;

    assign result_ch.valid      = out_valid_reg;
    assign result_ch.average    = out_average_reg;
    assign result_ch.force_high = out_force_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_low_reg  <= THRESHOLD_LOW_RST;
            thr_high_reg <= THRESHOLD_HIGH_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_THRESHOLD_LOW:  thr_low_reg  <= cfg_data[SAMPLE_W-1:0];
                REG_THRESHOLD_HIGH: thr_high_reg <= cfg_data[SAMPLE_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (sample_ch.ready)
            begin
                in_valid_reg <= sample_ch.valid;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample_ch.valid && sample_ch.ready)
        begin
            in_sample_reg <= sample_ch.sample;
        end
        if (step_en)
        begin
            out_average_reg <= average;
            out_force_reg   <= force_next;
        end
    end

    mah_ring_avg u_ring_avg (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (step_en),
        .sample  (in_sample_reg),
        .average (average)
    );

    mah_hyst u_hyst (
        .clk        (clk),
        .rst_n      (rst_n),
        .step_en    (step_en),
        .average    (average),
        .thr_low    (thr_low_reg),
        .thr_high   (thr_high_reg),
        .force_next (force_next)
    );

endmodule
